### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// Every assertion samples on the rising edge of i_clk and is held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// An antecedent that must be followed by a consequent in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An antecedent that must be followed by a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Types, codes and sizes shared by the positional list block.
// ----------------------------------------------------------------------------
package plist_pkg;

    // Number of list cells.
    localparam int CAPACITY = 8;

    // Width that holds an entry count from 0 up to CAPACITY.
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    // Width of the count and position fields of the words.
    localparam int COUNT_W = 4;
    localparam int POS_W   = 4;
    // Width used when positions and counts are compared.
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [31:0]  t_word;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CMP_W-1:0]    t_cmp;
    typedef logic [2:0]          t_mode;
    typedef logic [1:0]          t_status;

    // Operation codes.
    localparam t_mode MODE_INS_AT    = 3'd0;
    localparam t_mode MODE_INS_FRONT = 3'd1;
    localparam t_mode MODE_INS_END   = 3'd2;
    localparam t_mode MODE_REM_AT    = 3'd3;
    localparam t_mode MODE_REM_FRONT = 3'd4;
    localparam t_mode MODE_REM_END   = 3'd5;

    // Status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INS_FAIL = 2'd1;
    localparam t_status ST_REM_FAIL = 2'd2;

    typedef struct packed {
        t_mode             mode;
        logic [POS_W-1:0]  position;
        t_word             value;
    } t_in_word;

    typedef struct packed {
        t_word    removed_value;
        t_status  status;
        t_count   count;
    } t_out_word;

    // Per-cell control for one update cycle.
    typedef struct packed {
        logic load_new;    // take the broadcast word
        logic take_left;   // take the lower neighbor's word (insert shift)
        logic take_right;  // take the upper neighbor's word (remove shift)
        logic rd_sel;      // drive the held word onto the read tap
    } t_cell_ctl;

endpackage

### design/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: holds a word and trades it with its neighbors on a shift.
// ----------------------------------------------------------------------------
module plist_cell (
    input  logic                 i_clk,
    input  plist_pkg::t_cell_ctl i_ctl,
    input  plist_pkg::t_word     i_word,
    input  plist_pkg::t_word     i_left,
    input  plist_pkg::t_word     i_right,
    output plist_pkg::t_word     o_word,
    output plist_pkg::t_word     o_tap
);

    plist_pkg::t_word r_word;
    plist_pkg::t_word n_word;

    always_comb begin
        if (i_ctl.load_new) begin
            n_word = i_word;
        end else if (i_ctl.take_left) begin
            n_word = i_left;
        end else if (i_ctl.take_right) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    // Slot contents carry no reset; only slots below the count are read.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = i_ctl.rd_sel ? r_word : '0;

endmodule

### design/positional_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// Fixed-capacity ordered list of signed words with positional insert/remove.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                    Word
//   in        input       i_in_valid / o_in_ready      i_in_word  (t_in_word)
//   out       output      o_out_valid / i_out_ready    o_out_word (t_out_word)
//
// For every accepted word the cell row shifts and the result word is loaded
// into the output register at the same clock edge, so the block sustains
// one word per cycle while the output side keeps taking.
// The single output register is the only buffering; the input is ready when
// that register is empty or is being taken in the same cycle.
// Reset (synchronous, active low) clears the entry count and the output valid
// flag; the cell contents are left as they are and are never read before a
// write.
module positional_list_insert_remove_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  plist_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output plist_pkg::t_out_word o_out_word
);

    // ------------------------------------------------------------------
    // Handshake and state registers.
    // ------------------------------------------------------------------
    logic                  in_fire;
    plist_pkg::t_cnt       r_count;
    plist_pkg::t_cnt       n_count;
    logic                  r_out_valid;
    plist_pkg::t_out_word  r_out_word;
    plist_pkg::t_out_word  n_out_word;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Operation decode. Each mode reduces to an insert or a remove at a
    // target slot; unknown modes do neither and report success.
    // ------------------------------------------------------------------
    plist_pkg::t_cmp cnt_x;
    plist_pkg::t_cmp pos_x;
    plist_pkg::t_cmp tgt;
    logic            is_ins;
    logic            is_rem;
    logic            ins_ok;
    logic            rem_ok;

    assign cnt_x = plist_pkg::t_cmp'(r_count);
    assign pos_x = plist_pkg::t_cmp'(i_in_word.position);

    always_comb begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        tgt    = '0;
        case (i_in_word.mode)
            plist_pkg::MODE_INS_AT: begin
                is_ins = 1'b1;
                tgt    = pos_x;
            end
            plist_pkg::MODE_INS_FRONT: begin
                is_ins = 1'b1;
            end
            plist_pkg::MODE_INS_END: begin
                is_ins = 1'b1;
                tgt    = cnt_x;
            end
            plist_pkg::MODE_REM_AT: begin
                is_rem = 1'b1;
                tgt    = pos_x;
            end
            plist_pkg::MODE_REM_FRONT: begin
                is_rem = 1'b1;
            end
            plist_pkg::MODE_REM_END: begin
                // An empty list wraps this target, but the remove is refused
                // on the empty check anyway.
                is_rem = 1'b1;
                tgt    = cnt_x - plist_pkg::t_cmp'(1);
            end
            default: begin
                is_ins = 1'b0;
                is_rem = 1'b0;
            end
        endcase
    end

    // An insert needs a free slot and a target no higher than the count;
    // a remove needs a target below the count, which also rules out empty.
    assign ins_ok = is_ins && (cnt_x < plist_pkg::t_cmp'(plist_pkg::CAPACITY))
                           && (tgt <= cnt_x);
    assign rem_ok = is_rem && (cnt_x != '0) && (tgt < cnt_x);

    // ------------------------------------------------------------------
    // Cell row. Each cell compares its own index with the target: on an
    // insert, cells above the target take their lower neighbor and the
    // target cell takes the new word; on a remove, cells from the target
    // upward take their upper neighbor. The top cell keeps its stale word
    // on a remove, which lies beyond the new count.
    // ------------------------------------------------------------------
    plist_pkg::t_cell_ctl cell_ctl [plist_pkg::CAPACITY];
    plist_pkg::t_word     cell_word [plist_pkg::CAPACITY];
    plist_pkg::t_word     cell_tap  [plist_pkg::CAPACITY];

    for (genvar g = 0; g < plist_pkg::CAPACITY; g++) begin : g_cell
        plist_pkg::t_cmp  idx;
        plist_pkg::t_word left_word;
        plist_pkg::t_word right_word;

        assign idx = plist_pkg::t_cmp'(g);

        assign cell_ctl[g].load_new  = in_fire && ins_ok && (idx == tgt);
        assign cell_ctl[g].take_left = in_fire && ins_ok && (idx > tgt);
        assign cell_ctl[g].rd_sel    = (idx == tgt);

        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_inner_left
            assign left_word = cell_word[g-1];
        end

        if (g == plist_pkg::CAPACITY - 1) begin : g_last
            assign right_word               = '0;
            assign cell_ctl[g].take_right   = 1'b0;
        end else begin : g_inner_right
            assign right_word               = cell_word[g+1];
            assign cell_ctl[g].take_right   = in_fire && rem_ok && (idx >= tgt);
        end

        plist_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_word  (i_in_word.value),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (cell_word[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // Read port: at most one tap is live, so an OR over the row selects it.
    plist_pkg::t_word rd_word;

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < plist_pkg::CAPACITY; k++) begin
            rd_word = rd_word | cell_tap[k];
        end
    end

    // ------------------------------------------------------------------
    // Next count and result word.
    // ------------------------------------------------------------------
    always_comb begin
        n_count                  = r_count;
        n_out_word.removed_value = '0;
        n_out_word.status        = plist_pkg::ST_OK;
        if (is_ins) begin
            if (ins_ok) begin
                n_count = r_count + plist_pkg::t_cnt'(1);
            end else begin
                n_out_word.status = plist_pkg::ST_INS_FAIL;
            end
        end else if (is_rem) begin
            if (rem_ok) begin
                n_count                  = r_count - plist_pkg::t_cnt'(1);
                n_out_word.removed_value = rd_word;
            end else begin
                n_out_word.status = plist_pkg::ST_REM_FAIL;
            end
        end
        n_out_word.count = plist_pkg::t_count'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

### design/plist_checker.sv
// ----------------------------------------------------------------------------
// plist_checker
// Port-level checks on the positional list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plist_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input plist_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input plist_pkg::t_out_word o_out_word
);

    // A result word stays offered, unchanged, until it is taken.
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
                 o_out_valid && $stable(o_out_word))

    // Every accepted word yields a result in the next cycle.
    `ASSERT_NEXT(a_in_to_out, i_in_valid && o_in_ready, o_out_valid)

    // The reported count never exceeds the list capacity.
    `ASSERT_SAME(a_count_cap, o_out_valid,
                 32'(o_out_word.count) <= 32'(plist_pkg::CAPACITY))

    // A refused operation returns no word.
    `ASSERT_SAME(a_fail_zero, o_out_valid && (o_out_word.status != plist_pkg::ST_OK),
                 o_out_word.removed_value == '0)

endmodule

bind positional_list_insert_remove_top plist_checker u_plist_checker (.*);

### tb/positional_list_insert_remove_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top_test
// Self-checking bench for the positional list: a short table of directed
// words covers the refusals and the field extremes, and a long run of
// shaped random words follows. A behavioral copy of the list predicts the
// result word for every accepted input word.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_top_test;

    import plist_pkg::*;

    // At least 1950 input words in total: the table plus the random part.
    localparam int DIRECTED_OPS   = 24;
    localparam int RANDOM_OPS     = 1926;
    localparam int MAX_IDLE       = 18;
    // Worst correct case is a sender gap plus a receiver stall back to back;
    // the limit is many times that.
    localparam int WATCHDOG_LIMIT = 1000;
    // The block answers in the cycle after it accepts a word.
    localparam int DRAIN_CYCLES   = 10;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    // One row of the directed table. Where typed is set, the result word is
    // written out here; elsewhere the predictor supplies it.
    typedef struct {
        t_in_word  op;
        bit        typed;
        t_out_word result;
    } t_plan_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_word  in_word   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Behavioral copy of the list contents and its fill level.
    t_word     list_cells [CAPACITY];
    int        list_len  = 0;

    // Result words still owed by the block, oldest first.
    t_out_word expected_results [$];
    int        fail_count   = 0;
    int        stuck_cycles = 0;

    // Each side alternates between stretches of random idling and
    // stretches in which it never idles.
    bit        in_rush  = 1'b0;
    bit        out_rush = 1'b0;

    t_plan_row op_table [DIRECTED_OPS];

    positional_list_insert_remove_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 clk = ~clk;

    // Applies one operation to the list copy and returns the result word.
    // Inserts shift the later cells up, removes shift them down; refused
    // operations and the two unused mode codes leave the list untouched.
    function automatic t_out_word apply_list_op(input t_in_word op);
        t_out_word res;
        int        slot;
        int        k;
        res.removed_value = '0;
        res.status        = ST_OK;
        case (op.mode)
            MODE_INS_AT, MODE_INS_FRONT, MODE_INS_END: begin
                if (op.mode == MODE_INS_AT)
                    slot = int'(op.position);
                else if (op.mode == MODE_INS_FRONT)
                    slot = 0;
                else
                    slot = list_len;
                if (list_len >= CAPACITY || slot > list_len) begin
                    res.status = ST_INS_FAIL;
                end else begin
                    for (k = list_len; k > slot; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[slot] = op.value;
                    list_len++;
                end
            end
            MODE_REM_AT, MODE_REM_FRONT, MODE_REM_END: begin
                if (op.mode == MODE_REM_AT)
                    slot = int'(op.position);
                else if (op.mode == MODE_REM_FRONT)
                    slot = 0;
                else
                    slot = list_len - 1;
                if (list_len == 0 || slot >= list_len) begin
                    res.status = ST_REM_FAIL;
                end else begin
                    res.removed_value = list_cells[slot];
                    for (k = slot; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.count = t_count'(list_len);
        return res;
    endfunction

    function automatic t_plan_row op_row(input t_mode mode, input int pos, input t_word value,
                                         input bit typed, input t_word rem,
                                         input t_status st, input int cnt);
        t_plan_row row;
        row.op.mode              = mode;
        row.op.position          = pos[POS_W-1:0];
        row.op.value             = value;
        row.typed                = typed;
        row.result.removed_value = rem;
        row.result.status        = st;
        row.result.count         = t_count'(cnt);
        return row;
    endfunction

    // Offers one word to the block after a random gap and waits for it to
    // be taken. Valid is only lowered when a gap actually follows, so a
    // back-to-back word never sees valid drop and rise in one step.
    task automatic send_list_op(input t_in_word op, input bit typed,
                                input t_out_word typed_res);
        int        gap;
        t_out_word predicted;
        if ($urandom_range(0, 31) == 0)
            in_rush = !in_rush;
        gap = in_rush ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= op;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        // The predictor always runs so that its list stays in step, even
        // when the row carries its own expected word.
        predicted = apply_list_op(op);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // Receiver: a fresh stall is drawn for every result word, so that
    // back-pressure lands both while a word waits and while none is there.
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 31) == 0)
                out_rush = !out_rush;
            stall = out_rush ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(o_out_valid === 1'b1 && rst_n));
        end
    end

    // Checker: every word taken from the output is matched field by field
    // against the oldest outstanding expectation.
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word taken with no expectation pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_word.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed_value, o_out_word.removed_value);
                    fail_count++;
                end
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d",
                           want.status, o_out_word.status);
                    fail_count++;
                end
                if (o_out_word.count !== want.count) begin
                    $error("count: expected %0d, got %0d",
                           want.count, o_out_word.count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge clk) begin
        if ((in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_in_word  op;
        t_out_word none;
        int        sent;
        int        pick;
        bit        filling;
        none    = '0;
        filling = 1'b1;

        // Directed table. It starts from an empty list: every removal is
        // refused, inserts beyond the end are refused, and the unused mode
        // codes change nothing. The list is then filled with the extreme
        // words through every insert flavor until it is full, inserts into
        // a full list are refused, removals at and past the end are tried,
        // and every remove flavor drains part of it again.
        op_table[0]  = op_row(MODE_REM_FRONT, 0, 0, TYPED, 0, ST_REM_FAIL, 0);
        op_table[1]  = op_row(MODE_REM_END, 0, 0, TYPED, 0, ST_REM_FAIL, 0);
        op_table[2]  = op_row(MODE_REM_AT, 0, -1, TYPED, 0, ST_REM_FAIL, 0);
        op_table[3]  = op_row(MODE_INS_AT, 1, 5, TYPED, 0, ST_INS_FAIL, 0);
        op_table[4]  = op_row(MODE_INS_AT, 15, -1, TYPED, 0, ST_INS_FAIL, 0);
        op_table[5]  = op_row(t_mode'(6), 0, 0, TYPED, 0, ST_OK, 0);
        op_table[6]  = op_row(t_mode'(7), 15, -1, TYPED, 0, ST_OK, 0);
        op_table[7]  = op_row(MODE_INS_AT, 0, t_word'(32'h8000_0000), TYPED, 0, ST_OK, 1);
        op_table[8]  = op_row(MODE_INS_FRONT, 15, t_word'(32'h7FFF_FFFF),
                              TYPED, 0, ST_OK, 2);
        op_table[9]  = op_row(MODE_INS_END, 9, -1, TYPED, 0, ST_OK, 3);
        op_table[10] = op_row(MODE_INS_AT, 3, t_word'(32'h5A5A_5A5A), TYPED, 0, ST_OK, 4);
        op_table[11] = op_row(MODE_INS_AT, 2, t_word'(32'h1234_5678),
                              PREDICTED, 0, ST_OK, 0);
        op_table[12] = op_row(MODE_INS_FRONT, 0, 0, PREDICTED, 0, ST_OK, 0);
        op_table[13] = op_row(MODE_INS_END, 0, t_word'(32'hA5A5_A5A5),
                              PREDICTED, 0, ST_OK, 0);
        op_table[14] = op_row(MODE_INS_AT, 4, 1, PREDICTED, 0, ST_OK, 0);
        op_table[15] = op_row(MODE_INS_END, 0, 7, TYPED, 0, ST_INS_FAIL, 8);
        op_table[16] = op_row(MODE_INS_AT, 0, 7, TYPED, 0, ST_INS_FAIL, 8);
        op_table[17] = op_row(MODE_REM_AT, 8, 0, TYPED, 0, ST_REM_FAIL, 8);
        op_table[18] = op_row(MODE_REM_AT, 15, 0, TYPED, 0, ST_REM_FAIL, 8);
        op_table[19] = op_row(MODE_REM_AT, 7, 0, PREDICTED, 0, ST_OK, 0);
        op_table[20] = op_row(MODE_REM_FRONT, 6, 3, PREDICTED, 0, ST_OK, 0);
        op_table[21] = op_row(MODE_REM_END, 15, -1, PREDICTED, 0, ST_OK, 0);
        op_table[22] = op_row(MODE_REM_AT, 2, -1, PREDICTED, 0, ST_OK, 0);
        op_table[23] = op_row(t_mode'(6), 0, -1, TYPED, 0, ST_OK, 4);

        // Synchronous reset, applied from time zero and then released.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (op_table[i])
            send_list_op(op_table[i].op, op_table[i].typed, op_table[i].result);

        // Random part. The list sweeps between empty and full so that both
        // refusal cases come up often; most positions are legal for the
        // current fill level, the rest cover the whole field. The unused
        // mode codes show up as noise and are not counted.
        sent = 0;
        while (sent < RANDOM_OPS) begin
            if (list_len == CAPACITY)
                filling = 1'b0;
            else if (list_len == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 19) == 0)
                filling = !filling;

            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                op.mode = t_mode'($urandom_range(6, 7));
                op.position = POS_W'($urandom_range(0, 15));
            end else begin
                pick = $urandom_range(0, 99);
                if (filling ? pick < 75 : pick < 25) begin
                    op.mode = t_mode'($urandom_range(int'(MODE_INS_AT), int'(MODE_INS_END)));
                    if ($urandom_range(0, 99) < 85)
                        op.position = POS_W'($urandom_range(0, list_len));
                    else
                        op.position = POS_W'($urandom_range(0, 15));
                end else begin
                    op.mode = t_mode'($urandom_range(int'(MODE_REM_AT), int'(MODE_REM_END)));
                    if ($urandom_range(0, 99) < 85 && list_len > 0)
                        op.position = POS_W'($urandom_range(0, list_len - 1));
                    else
                        op.position = POS_W'($urandom_range(0, 15));
                end
                sent++;
            end

            // Mostly full-range words, with the extremes mixed in.
            case ($urandom_range(0, 9))
                0:       op.value = t_word'(32'h8000_0000);
                1:       op.value = t_word'(32'h7FFF_FFFF);
                2:       op.value = '0;
                3:       op.value = '1;
                default: op.value = t_word'($urandom);
            endcase

            send_list_op(op, PREDICTED, none);
        end
        in_valid <= 1'b0;

        // Let the last result words come out, then go on clocking so that a
        // stray extra word would still be caught.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
